FILE: src/assert_macros.svh
// Assertion macros used by the waveform engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check that an expression never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `ASSERT_PROP(lbl, clk, rst_n, !(expr))

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: src/lpws_pkg.sv
// Types and constants of the LED pulse width serializer
package lpws_pkg;

    localparam int unsigned WORD_BITS = 24;
    localparam int unsigned BYTE_BITS = 8;
    localparam int unsigned PAYLOAD_W = 24;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned BITS_W    = $clog2(WORD_BITS + 1);
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_WORD  = 2'd2;
    localparam logic [1:0] OP_LATCH = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LATCH     = 2'd3;

    typedef struct packed {
        logic [1:0]           operation;
        logic [PAYLOAD_W-1:0] payload;
    } t_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
        logic finished;
    } t_res;

    typedef struct packed {
        logic [TICK_W-1:0] one_high_ticks;
        logic [TICK_W-1:0] zero_high_ticks;
        logic [TICK_W-1:0] bit_period_ticks;
        logic [TICK_W-1:0] latch_low_ticks;
    } t_cfg;

endpackage

FILE: src/lpws_cfg_regs.sv
// Timing configuration registers
module lpws_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lpws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lpws_pkg::TICK_W-1:0]    i_cfg_data,
    output lpws_pkg::t_cfg                o_cfg
);
    import lpws_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high_ticks   <= TICK_W'(60);
            r_cfg.zero_high_ticks  <= TICK_W'(25);
            r_cfg.bit_period_ticks <= TICK_W'(125);
            r_cfg.latch_low_ticks  <= TICK_W'(6000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ONE_HIGH:  r_cfg.one_high_ticks   <= i_cfg_data;
                REG_ZERO_HIGH: r_cfg.zero_high_ticks  <= i_cfg_data;
                REG_PERIOD:    r_cfg.bit_period_ticks <= i_cfg_data;
                REG_LATCH:     r_cfg.latch_low_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/lpws_engine.sv
// Waveform state and per-tick next-state logic
`include "assert_macros.svh"

module lpws_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  lpws_pkg::t_item i_item,
    input  lpws_pkg::t_cfg  i_cfg,
    output lpws_pkg::t_res  o_res
);
    import lpws_pkg::*;

    logic [WORD_BITS-1:0] r_shift;
    logic [WORD_BITS-1:0] n_shift;
    logic [BITS_W-1:0]    r_bits;
    logic [BITS_W-1:0]    n_bits;
    logic [TICK_W-1:0]    r_phase;
    logic [TICK_W-1:0]    n_phase;
    logic                 r_latch;
    logic                 n_latch;

    logic              idle;
    logic [TICK_W-1:0] latch_last;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] period_last;
    logic [TICK_W-1:0] high_raw;
    logic [TICK_W-1:0] high_sat;
    t_res              res;

    assign idle        = (r_bits == '0) && !r_latch;
    assign latch_last  = (i_cfg.latch_low_ticks == '0) ? '0 : i_cfg.latch_low_ticks - 1'b1;
    assign period      = (i_cfg.bit_period_ticks == '0) ? TICK_W'(1) : i_cfg.bit_period_ticks;
    assign period_last = period - 1'b1;

    always_comb begin
        n_shift  = r_shift;
        n_bits   = r_bits;
        n_phase  = r_phase;
        n_latch  = r_latch;
        res      = '0;
        high_raw = '0;
        high_sat = '0;

        // start a command on the same tick
        if (idle) begin
            case (i_item.operation)
                OP_BYTE: begin
                    res.accepted = 1'b1;
                    n_phase      = '0;
                    n_shift      = {i_item.payload[BYTE_BITS-1:0], {(WORD_BITS-BYTE_BITS){1'b0}}};
                    n_bits       = BITS_W'(BYTE_BITS);
                end
                OP_WORD: begin
                    res.accepted = 1'b1;
                    n_phase      = '0;
                    n_shift      = WORD_BITS'(i_item.payload);
                    n_bits       = BITS_W'(WORD_BITS);
                end
                OP_LATCH: begin
                    res.accepted = 1'b1;
                    n_phase      = '0;
                    n_latch      = 1'b1;
                end
                OP_TICK: ;
                default: ;
            endcase
        end

        if (n_latch) begin
            res.busy_res = 1'b1;
            if (n_phase >= latch_last) begin
                n_latch      = 1'b0;
                n_phase      = '0;
                res.finished = 1'b1;
            end else begin
                n_phase = n_phase + 1'b1;
            end
        end else if (n_bits != '0) begin
            high_raw       = n_shift[WORD_BITS-1] ? i_cfg.one_high_ticks
                                                  : i_cfg.zero_high_ticks;
            high_sat       = (high_raw > period) ? period : high_raw;
            res.busy_res   = 1'b1;
            res.line_level = (n_phase < high_sat);
            if (n_phase >= period_last) begin
                n_phase = '0;
                n_shift = {n_shift[WORD_BITS-2:0], 1'b0};
                n_bits  = n_bits - 1'b1;
                if (n_bits == '0) begin
                    res.finished = 1'b1;
                end
            end else begin
                n_phase = n_phase + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_bits  <= '0;
            r_phase <= '0;
            r_latch <= 1'b0;
        end else if (i_advance) begin
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_phase <= n_phase;
            r_latch <= n_latch;
        end
    end

    assign o_res = res;

    `ASSERT_NEVER(a_latch_excl_send, i_clk, i_rst_n, r_latch && (r_bits != '0))
    `ASSERT_NEVER(a_bits_range, i_clk, i_rst_n, r_bits > BITS_W'(WORD_BITS))
    `ASSERT_PROP(a_refuse_busy, i_clk, i_rst_n, !idle |-> !res.accepted)
    `ASSERT_PROP(a_finish_idle, i_clk, i_rst_n, (i_advance && res.finished) |=> idle)
    `ASSERT_PROP(a_finish_busy, i_clk, i_rst_n, (i_advance && res.finished) |-> res.busy_res)

endmodule

FILE: src/led_pulse_width_serializer.sv
// An item is captured in the input register and its result in the result register.
// Throughput: one item per cycle; the input and result registers keep
// taking items while the result side is not stalled.
// The waveform state advances once per item in a single pass of logic.
// Reset (synchronous, active low) empties both registers, clears the state
// and loads the timing registers with their default values.
module led_pulse_width_serializer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  lpws_pkg::t_item                i_item,
    output logic                           o_valid,
    input  logic                           i_stall,
    output lpws_pkg::t_res                 o_res,
    input  logic                           i_cfg_we,
    input  logic [lpws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lpws_pkg::TICK_W-1:0]    i_cfg_data
);
    import lpws_pkg::*;

    t_item r_in;
    logic  r_in_valid;
    t_res  r_out;
    logic  r_out_valid;
    logic  advance;
    logic  in_take;
    t_cfg  cfg;
    t_res  res;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    lpws_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lpws_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

FILE: sim/tb_led_pulse_width_serializer.sv
// Testbench for the LED pulse width serializer: tick-by-tick line prediction and checking
`timescale 1ns / 1ps

module tb_led_pulse_width_serializer;
    import lpws_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned END_WAIT      = 8;
    localparam int unsigned RANDOM_PHASES = 4;
    localparam int unsigned PHASE_ITEMS   = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    t_item                i_item;
    logic                 o_valid;
    logic                 i_stall;
    t_res                 o_res;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TICK_W-1:0]    i_cfg_data;

    led_pulse_width_serializer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_cfg               timing;
    logic [WORD_BITS-1:0] sh_word;
    logic [BITS_W-1:0]  bits_togo;
    logic [TICK_W-1:0]  cell_pos;
    logic               in_latch;

    t_res               expected_wave[$];
    string              res_field[4] = '{"line_level", "busy_res", "accepted", "finished"};
    int unsigned        mismatches;
    int unsigned        cycles;
    int unsigned        burst_left;
    int unsigned        stall_left;
    int unsigned        stall_mode;

    always #5 i_clk = ~i_clk;

    function automatic logic line_busy();
        return (bits_togo != 0) || in_latch;
    endfunction

    function automatic t_res advance_line(input t_item it);
        t_res        r;
        int unsigned len;
        int unsigned high;
        r = '0;
        if (!line_busy() && it.operation != OP_TICK) begin
            r.accepted = 1'b1;
            cell_pos   = '0;
            case (it.operation)
                OP_BYTE: begin
                    sh_word   = {it.payload[BYTE_BITS-1:0], {(WORD_BITS-BYTE_BITS){1'b0}}};
                    bits_togo = BITS_W'(BYTE_BITS);
                end
                OP_WORD: begin
                    sh_word   = it.payload[WORD_BITS-1:0];
                    bits_togo = BITS_W'(WORD_BITS);
                end
                default: begin
                    in_latch = 1'b1;
                end
            endcase
        end
        if (in_latch) begin
            len        = (timing.latch_low_ticks == 0) ? 1 : 32'(timing.latch_low_ticks);
            r.busy_res = 1'b1;
            if (cell_pos >= len - 1) begin
                in_latch   = 1'b0;
                cell_pos   = '0;
                r.finished = 1'b1;
            end else begin
                cell_pos = cell_pos + 1'b1;
            end
        end else if (bits_togo != 0) begin
            len  = (timing.bit_period_ticks == 0) ? 1 : 32'(timing.bit_period_ticks);
            high = sh_word[WORD_BITS-1] ? 32'(timing.one_high_ticks)
                                        : 32'(timing.zero_high_ticks);
            if (high > len)
                high = len;
            r.busy_res   = 1'b1;
            r.line_level = (cell_pos < high);
            if (cell_pos >= len - 1) begin
                cell_pos  = '0;
                sh_word   = sh_word << 1;
                bits_togo = bits_togo - 1'b1;
                if (bits_togo == 0)
                    r.finished = 1'b1;
            end else begin
                cell_pos = cell_pos + 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [PAYLOAD_W-1:0] data);
        t_item it;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
        end
        it.operation = op;
        it.payload   = data;
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        expected_wave.push_back(advance_line(it));
        burst_left--;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, PAYLOAD_W'($urandom));
    endtask

    // keep ticking until the running command ends, with refused commands mixed in
    task automatic finish_command();
        logic [1:0] op;
        while (line_busy()) begin
            op = OP_TICK;
            if ($urandom_range(0, 5) == 0)
                op = 2'($urandom_range(OP_BYTE, OP_LATCH));
            send_item(op, PAYLOAD_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_wave.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic write_cfg(input int unsigned one_high, input int unsigned zero_high,
                             input int unsigned period, input int unsigned latch_len);
        wait_drained();
        write_reg(REG_ONE_HIGH, TICK_W'(one_high));
        write_reg(REG_ZERO_HIGH, TICK_W'(zero_high));
        write_reg(REG_PERIOD, TICK_W'(period));
        write_reg(REG_LATCH, TICK_W'(latch_len));
        i_cfg_we <= 1'b0;
        timing.one_high_ticks   = TICK_W'(one_high);
        timing.zero_high_ticks  = TICK_W'(zero_high);
        timing.bit_period_ticks = TICK_W'(period);
        timing.latch_low_ticks  = TICK_W'(latch_len);
    endtask

    function automatic int unsigned rand_ticks(input int unsigned top, input bit allow_max);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return allow_max ? 65535 : 2;
            default: return $urandom_range(1, top);
        endcase
    endfunction

    task automatic test_default_timing();
        send_item(OP_BYTE, 24'h0000A5);
        repeat (130) send_tick();
        // shrink the cell below the current position while a bit is in flight
        write_cfg(3, 1, 4, 3);
        finish_command();
    endtask

    task automatic test_directed();
        write_cfg(3, 1, 4, 3);
        repeat (3) send_tick();
        send_item(OP_BYTE, 24'hFFFFFF);
        finish_command();
        send_item(OP_BYTE, 24'hFFFF00);
        finish_command();
        send_item(OP_WORD, 24'hFFFFFF);
        finish_command();
        send_item(OP_WORD, 24'h000000);
        finish_command();
        send_item(OP_WORD, 24'h800001);
        finish_command();
        send_item(OP_LATCH, 24'h5A5A5A);
        finish_command();
        send_item(OP_LATCH, 24'h000000);
        send_item(OP_WORD, 24'hFFFFFF);
        finish_command();
    endtask

    task automatic test_saturation();
        write_cfg(9, 0, 5, 0);
        send_item(OP_WORD, PAYLOAD_W'($urandom));
        finish_command();
        send_item(OP_LATCH, PAYLOAD_W'($urandom));
        finish_command();
        write_cfg(65535, 65535, 0, 1);
        send_item(OP_BYTE, PAYLOAD_W'($urandom));
        finish_command();
        send_item(OP_LATCH, PAYLOAD_W'($urandom));
        finish_command();
        write_cfg(1, 1, 2, 2);
        send_item(OP_WORD, 24'hC3A596);
        finish_command();
    endtask

    task automatic test_extremes();
        write_cfg(65535, 1, 65535, 65535);
        send_item(OP_BYTE, 24'h000081);
        repeat (20) send_tick();
        write_cfg(2, 1, 3, 65535);
        finish_command();
        send_item(OP_LATCH, PAYLOAD_W'($urandom));
        repeat (20) send_tick();
        write_cfg(2, 1, 3, 1);
        finish_command();
        write_cfg(0, 0, 1, 1);
        send_item(OP_WORD, PAYLOAD_W'($urandom));
        finish_command();
    endtask

    task automatic test_random();
        logic [1:0] op;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_cfg(rand_ticks(10, 1'b1), rand_ticks(10, 1'b1), rand_ticks(8, 1'b0),
                      rand_ticks(12, 1'b0));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = OP_TICK;
                if (!line_busy()) begin
                    if ($urandom_range(0, 9) < 7)
                        op = 2'($urandom_range(OP_BYTE, OP_LATCH));
                end else if ($urandom_range(0, 9) == 0) begin
                    op = 2'($urandom_range(OP_BYTE, OP_LATCH));
                end
                send_item(op, PAYLOAD_W'($urandom));
            end
        end
    endtask

    always @(posedge i_clk) begin : check_res
        t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_wave.size() == 0) begin
                $display("%0t: result with none expected, got %b", $time, o_res);
                mismatches++;
            end else begin
                want = expected_wave.pop_front();
                for (int f = 0; f < 4; f++) begin
                    if (o_res[3-f] !== want[3-f]) begin
                        $display("%0t: %s expected %b got %b", $time, res_field[f],
                                 want[3-f], o_res[3-f]);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 2) == 0);
            default: i_stall <= (cycles[1:0] == 2'b11);
        endcase
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("led_pulse_width_serializer test failed");
            $finish;
        end
    end

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_ONE_HIGH;
        i_cfg_data  = '0;
        cycles      = 0;
        mismatches  = 0;
        burst_left  = 0;
        stall_left  = 0;
        stall_mode  = 0;
        sh_word     = '0;
        bits_togo   = '0;
        cell_pos    = '0;
        in_latch    = 1'b0;
        timing.one_high_ticks   = 16'd60;
        timing.zero_high_ticks  = 16'd25;
        timing.bit_period_ticks = 16'd125;
        timing.latch_low_ticks  = 16'd6000;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_timing();
        test_directed();
        test_saturation();
        test_extremes();
        test_random();

        wait_drained();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("led_pulse_width_serializer test passed");
        else
            $display("led_pulse_width_serializer test failed");
        $finish;
    end

endmodule

FILE: led_pulse_width_serializer.f
+incdir+src
src/lpws_pkg.sv
src/lpws_cfg_regs.sv
src/lpws_engine.sv
src/led_pulse_width_serializer.sv
sim/tb_led_pulse_width_serializer.sv
